[src/aec16_pkg.sv]
// Shared types and constants for the CDF16 arithmetic encoder.
`default_nettype none
package aec16_pkg;

  localparam int PENDING_LIMIT = 255;
  localparam int PEND_W        = $clog2(PENDING_LIMIT + 2);
  localparam int MAX_RESULTS   = 40;
  localparam int RES_W         = $clog2(MAX_RESULTS + 1);

  localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(PENDING_LIMIT);
  localparam logic [RES_W-1:0]  RES_MAX  = RES_W'(MAX_RESULTS);

  localparam logic [16:0] SCALE_TOTAL    = 17'h10000;
  localparam logic [31:0] HALF           = 32'h8000_0000;
  localparam logic [31:0] QUARTER        = 32'h4000_0000;
  localparam logic [31:0] THREE_QUARTERS = 32'hc000_0000;
  localparam logic [31:0] ALL_ONES       = 32'hffff_ffff;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_BAD  = 2'd1;
  localparam logic [1:0] STAT_OVF  = 2'd2;

  typedef struct packed {
    logic        command;
    logic [15:0] sym_low;
    logic [16:0] sym_high;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_TOP,
    S_MUL_BOT,
    S_NARROW,
    S_CHECK,
    S_RENORM,
    S_EMIT,
    S_FIN_PAD,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

[src/arithmetic_encoder_cdf16_core.sv]
// Top level of the CDF16 arithmetic encoder: sequencer, shared renorm unit and byte output.
//
//  channel | ports                        | beat
//  --------+------------------------------+-------------------------------------------
//  input   | in_valid  in_ready  in_data  | command, sym_low, sym_high
//  output  | out_valid out_ready out_beat | out_byte, byte_valid, last, status
//
//  Encode: S_MUL_TOP, S_MUL_BOT, S_NARROW, S_CHECK dry run, S_RENORM passes, S_EMIT per
//  coded bit (decided bits plus released pending bits), S_DONE; the renorm shift count
//  is at most about 18. Finish: S_EMIT for the closing bit and pending+1 opposite bits,
//  S_FIN_PAD, S_DONE. The single renorm step unit (compare, subtract, shift) serves both
//  passes; emission is one bit per cycle unless stalled. in_ready is high only in idle.
//  Reset: synchronous rst_n puts the coder at low 0, high all ones, nothing pending.
//  Output stalls hold the sequencer wherever a byte must leave; bytes past MAX_RESULTS in one item are dropped.
`default_nettype none
module arithmetic_encoder_cdf16_core (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  aec16_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output aec16_pkg::out_item_t  out_beat
);

  aec16_pkg::state_t state_r, state_nxt;

  // committed coder state
  logic [31:0]                  lo_r, lo_nxt;
  logic [31:0]                  hi_r, hi_nxt;
  logic [aec16_pkg::PEND_W-1:0] pend_r, pend_nxt;
  logic [7:0]                   pbyte_r, pbyte_nxt;
  logic [2:0]                   pcnt_r, pcnt_nxt;

  // item operands and narrowed interval
  logic [15:0]                  slo_r, slo_nxt;
  logic [16:0]                  shi_r, shi_nxt;
  logic [49:0]                  prod_r, prod_nxt;
  logic [31:0]                  nlo_r, nlo_nxt;
  logic [31:0]                  nhi_r, nhi_nxt;

  // working copies for the renorm passes
  logic [31:0]                  wlo_r, wlo_nxt;
  logic [31:0]                  whi_r, whi_nxt;
  logic [aec16_pkg::PEND_W-1:0] wpend_r, wpend_nxt;
  logic                         rel_bit_r, rel_bit_nxt;
  logic                         first_r, first_nxt;
  logic                         ret_fin_r, ret_fin_nxt;
  logic                         fin_r, fin_nxt;
  logic [1:0]                   status_r, status_nxt;

  // held byte: the latest byte waits here until we know if it is the last
  logic                         held_v_r, held_v_nxt;
  logic [7:0]                   held_byte_r, held_byte_nxt;
  logic [aec16_pkg::RES_W-1:0]  res_cnt_r, res_cnt_nxt;

  logic                         out_valid_r, out_valid_nxt;
  aec16_pkg::out_item_t         out_beat_r, out_beat_nxt;

  // ---------------------------------------------------------------------------
  // shared multiplier: range * sym_high, then range * sym_low
  logic [32:0] rng;
  logic [16:0] mul_b;
  assign rng   = {1'b0, hi_r} - {1'b0, lo_r} + 33'd1;
  assign mul_b = (state_r == aec16_pkg::S_MUL_TOP) ? shi_r : {1'b0, slo_r};
  assign prod_nxt = {17'd0, rng} * {33'd0, mul_b};

  // ---------------------------------------------------------------------------
  // shared renorm step unit on the working interval
  logic        dec_low, dec_high, dec_mid, dec_none;
  logic [31:0] step_lo, step_hi;
  always_comb begin
    dec_low  = ~whi_r[31];
    dec_high = ~dec_low & wlo_r[31];
    dec_mid  = ~dec_low & ~dec_high & (wlo_r[31:30] == 2'b01) & (whi_r[31:30] == 2'b10);
    dec_none = ~dec_low & ~dec_high & ~dec_mid;
    if (dec_low) begin
      step_lo = wlo_r;
      step_hi = whi_r;
    end else if (dec_high) begin
      step_lo = wlo_r - aec16_pkg::HALF;
      step_hi = whi_r - aec16_pkg::HALF;
    end else begin
      step_lo = wlo_r - aec16_pkg::QUARTER;
      step_hi = whi_r - aec16_pkg::QUARTER;
    end
    step_lo = {step_lo[30:0], 1'b0};
    step_hi = {step_hi[30:0], 1'b1};
  end

  logic ovf_hit;
  assign ovf_hit = dec_mid && (wpend_r >= aec16_pkg::PEND_MAX);

  // ---------------------------------------------------------------------------
  // bit emitter and byte completion
  logic       ebit;
  logic [7:0] pbyte_shift;
  logic       emit_last;
  logic       byte_evt;
  logic [7:0] byte_val;
  logic       byte_keep;
  logic       can_push;
  logic       stall;
  logic [2:0] pad_amt;
  logic       bad_iv;

  assign ebit        = first_r ? rel_bit_r : ~rel_bit_r;
  assign pbyte_shift = {pbyte_r[6:0], ebit};
  assign emit_last   = first_r ? (wpend_r == '0)
                               : (wpend_r == aec16_pkg::PEND_W'(1));
  assign pad_amt     = 3'(4'd8 - {1'b0, pcnt_r});
  assign bad_iv      = (in_data.sym_high <= {1'b0, in_data.sym_low}) ||
                       (in_data.sym_high > aec16_pkg::SCALE_TOTAL);

  always_comb begin
    byte_evt = 1'b0;
    byte_val = pbyte_shift;
    if (state_r == aec16_pkg::S_EMIT && pcnt_r == 3'd7) begin
      byte_evt = 1'b1;
    end else if (state_r == aec16_pkg::S_FIN_PAD && pcnt_r != 3'd0) begin
      byte_evt = 1'b1;
      byte_val = pbyte_r << pad_amt;
    end
  end

  assign byte_keep = byte_evt && (res_cnt_r < aec16_pkg::RES_MAX);
  assign can_push  = ~out_valid_r | out_ready;
  assign stall     = (byte_keep && held_v_r && !can_push) ||
                     (state_r == aec16_pkg::S_DONE && !can_push);

  // ---------------------------------------------------------------------------
  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aec16_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_data.command == aec16_pkg::CMD_FINISH) state_nxt = aec16_pkg::S_EMIT;
          else if (bad_iv)                              state_nxt = aec16_pkg::S_DONE;
          else                                          state_nxt = aec16_pkg::S_MUL_TOP;
        end
      end
      aec16_pkg::S_MUL_TOP: state_nxt = aec16_pkg::S_MUL_BOT;
      aec16_pkg::S_MUL_BOT: state_nxt = aec16_pkg::S_NARROW;
      aec16_pkg::S_NARROW:  state_nxt = aec16_pkg::S_CHECK;
      aec16_pkg::S_CHECK: begin
        if (dec_none)     state_nxt = aec16_pkg::S_RENORM;
        else if (ovf_hit) state_nxt = aec16_pkg::S_DONE;
      end
      aec16_pkg::S_RENORM: begin
        if (dec_none)                 state_nxt = aec16_pkg::S_DONE;
        else if (dec_low || dec_high) state_nxt = aec16_pkg::S_EMIT;
      end
      aec16_pkg::S_EMIT: begin
        if (!stall && emit_last) begin
          state_nxt = ret_fin_r ? aec16_pkg::S_FIN_PAD : aec16_pkg::S_RENORM;
        end
      end
      aec16_pkg::S_FIN_PAD: if (!stall) state_nxt = aec16_pkg::S_DONE;
      aec16_pkg::S_DONE:    if (!stall) state_nxt = aec16_pkg::S_IDLE;
      default:              state_nxt = aec16_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath and outputs
  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    pend_nxt      = pend_r;
    pbyte_nxt     = pbyte_r;
    pcnt_nxt      = pcnt_r;
    slo_nxt       = slo_r;
    shi_nxt       = shi_r;
    nlo_nxt       = nlo_r;
    nhi_nxt       = nhi_r;
    wlo_nxt       = wlo_r;
    whi_nxt       = whi_r;
    wpend_nxt     = wpend_r;
    rel_bit_nxt   = rel_bit_r;
    first_nxt     = first_r;
    ret_fin_nxt   = ret_fin_r;
    fin_nxt       = fin_r;
    status_nxt    = status_r;
    held_v_nxt    = held_v_r;
    held_byte_nxt = held_byte_r;
    res_cnt_nxt   = res_cnt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_beat_nxt  = out_beat_r;

    case (state_r)
      aec16_pkg::S_IDLE: begin
        if (in_valid) begin
          slo_nxt     = in_data.sym_low;
          shi_nxt     = in_data.sym_high;
          status_nxt  = bad_iv ? aec16_pkg::STAT_BAD : aec16_pkg::STAT_OK;
          fin_nxt     = (in_data.command == aec16_pkg::CMD_FINISH);
          held_v_nxt  = 1'b0;
          res_cnt_nxt = '0;
          if (in_data.command == aec16_pkg::CMD_FINISH) begin
            // closing bit picks the quarter the low bound sits in
            status_nxt  = aec16_pkg::STAT_OK;
            wpend_nxt   = pend_r + aec16_pkg::PEND_W'(1);
            rel_bit_nxt = |lo_r[31:30];
            first_nxt   = 1'b1;
            ret_fin_nxt = 1'b1;
          end
        end
      end
      aec16_pkg::S_MUL_BOT: begin
        nhi_nxt = lo_r + (prod_r[47:16] - 32'd1);
      end
      aec16_pkg::S_NARROW: begin
        nlo_nxt   = lo_r + prod_r[47:16];
        wlo_nxt   = lo_r + prod_r[47:16];
        whi_nxt   = nhi_r;
        wpend_nxt = pend_r;
      end
      aec16_pkg::S_CHECK: begin
        // dry run: find pending overflow before any bit leaves
        if (dec_none) begin
          wlo_nxt   = nlo_r;
          whi_nxt   = nhi_r;
          wpend_nxt = pend_r;
        end else if (ovf_hit) begin
          status_nxt = aec16_pkg::STAT_OVF;
        end else begin
          wlo_nxt   = step_lo;
          whi_nxt   = step_hi;
          wpend_nxt = dec_mid ? wpend_r + aec16_pkg::PEND_W'(1) : '0;
        end
      end
      aec16_pkg::S_RENORM: begin
        if (!dec_none) begin
          wlo_nxt = step_lo;
          whi_nxt = step_hi;
          if (dec_mid) begin
            wpend_nxt = wpend_r + aec16_pkg::PEND_W'(1);
          end else begin
            rel_bit_nxt = dec_high;
            first_nxt   = 1'b1;
            ret_fin_nxt = 1'b0;
          end
        end
      end
      aec16_pkg::S_EMIT: begin
        if (!stall) begin
          pbyte_nxt = (pcnt_r == 3'd7) ? 8'd0 : pbyte_shift;
          pcnt_nxt  = pcnt_r + 3'd1;
          if (first_r) first_nxt = 1'b0;
          else         wpend_nxt = wpend_r - aec16_pkg::PEND_W'(1);
        end
      end
      aec16_pkg::S_FIN_PAD: begin
        if (!stall) begin
          pbyte_nxt = 8'd0;
          pcnt_nxt  = 3'd0;
        end
      end
      aec16_pkg::S_DONE: begin
        if (!stall) begin
          out_valid_nxt = 1'b1;
          out_beat_nxt  = '{out_byte: (held_v_r ? held_byte_r : 8'd0),
                            byte_valid: held_v_r, last: 1'b1, status: status_r};
          held_v_nxt  = 1'b0;
          res_cnt_nxt = '0;
          if (fin_r) begin
            lo_nxt    = '0;
            hi_nxt    = aec16_pkg::ALL_ONES;
            pend_nxt  = '0;
            pbyte_nxt = 8'd0;
            pcnt_nxt  = 3'd0;
          end else if (status_r == aec16_pkg::STAT_OK) begin
            lo_nxt   = wlo_r;
            hi_nxt   = whi_r;
            pend_nxt = wpend_r;
          end
        end
      end
      default: ;
    endcase

    // a completed byte pushes the older held byte out as a non-final beat
    if (byte_keep && !stall) begin
      if (held_v_r) begin
        out_valid_nxt = 1'b1;
        out_beat_nxt  = '{out_byte: held_byte_r, byte_valid: 1'b1,
                          last: 1'b0, status: aec16_pkg::STAT_OK};
      end
      held_v_nxt    = 1'b1;
      held_byte_nxt = byte_val;
      res_cnt_nxt   = res_cnt_r + aec16_pkg::RES_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aec16_pkg::S_IDLE;
      lo_r        <= '0;
      hi_r        <= aec16_pkg::ALL_ONES;
      pend_r      <= '0;
      pbyte_r     <= '0;
      pcnt_r      <= '0;
      first_r     <= 1'b0;
      ret_fin_r   <= 1'b0;
      fin_r       <= 1'b0;
      status_r    <= aec16_pkg::STAT_OK;
      held_v_r    <= 1'b0;
      res_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      pend_r      <= pend_nxt;
      pbyte_r     <= pbyte_nxt;
      pcnt_r      <= pcnt_nxt;
      first_r     <= first_nxt;
      ret_fin_r   <= ret_fin_nxt;
      fin_r       <= fin_nxt;
      status_r    <= status_nxt;
      held_v_r    <= held_v_nxt;
      res_cnt_r   <= res_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slo_r       <= slo_nxt;
    shi_r       <= shi_nxt;
    prod_r      <= prod_nxt;
    nlo_r       <= nlo_nxt;
    nhi_r       <= nhi_nxt;
    wlo_r       <= wlo_nxt;
    whi_r       <= whi_nxt;
    wpend_r     <= wpend_nxt;
    rel_bit_r   <= rel_bit_nxt;
    held_byte_r <= held_byte_nxt;
    out_beat_r  <= out_beat_nxt;
  end

  assign in_ready  = (state_r == aec16_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

`ifndef SYNTH
  // idle means the previous item fully drained its byte buffer
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aec16_pkg::S_IDLE) |-> (!held_v_r && res_cnt_r == '0))
    else $error("held byte left over in idle");

  // a rejected item never produced a byte
  a_err_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aec16_pkg::S_DONE && status_r != aec16_pkg::STAT_OK) |-> !held_v_r)
    else $error("bytes produced by a rejected item");

  // committed pending count never passes the limit
  a_pend_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= aec16_pkg::PEND_MAX)
    else $error("pending count above limit");

  // a status-only beat always closes its item
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_beat_r.byte_valid) |-> out_beat_r.last)
    else $error("status-only beat without last");
`endif

endmodule
`default_nettype wire

[tb/sv/aec16_tb_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard class for the CDF16 arithmetic encoder testbench: coder model and beat checks.
package aec16_tb_pkg;
  import aec16_pkg::*;

  class coded_byte_board;
    logic [31:0] lo;
    logic [31:0] hi;
    int unsigned pend;
    int unsigned pcnt;
    logic [7:0]  pbyte;
    bit          overflowed;   // most recent item dropped for pending overflow
    int unsigned mismatches;
    int unsigned beats_seen;
    out_item_t   expected_beats[$];
    out_item_t   item_beats[$];

    function new();
      clear_coder();
      overflowed = 1'b0;
      mismatches = 0;
      beats_seen = 0;
    endfunction

    function void clear_coder();
      lo    = '0;
      hi    = ALL_ONES;
      pend  = 0;
      pcnt  = 0;
      pbyte = '0;
    endfunction

    // symbol index whose narrowed interval straddles the midpoint
    function logic [15:0] middle_symbol();
      logic [32:0] span;
      logic [63:0] s;
      span = {1'b0, hi} - {1'b0, lo} + 33'd1;
      s = (64'(HALF - lo) << 16) / 64'(span);
      if (s < 64'd1) s = 64'd1;
      if (s > 64'd65534) s = 64'd65534;
      return s[15:0];
    endfunction

    function void push_beat(logic [7:0] b, logic bv, logic [1:0] st);
      out_item_t r;
      r.out_byte   = b;
      r.byte_valid = bv;
      r.last       = 1'b0;
      r.status     = st;
      item_beats = {item_beats, r};
    endfunction

    function void put_bit(bit b);
      pbyte = {pbyte[6:0], b};
      pcnt++;
      if (pcnt == 8) begin
        push_beat(pbyte, 1'b1, STAT_OK);
        pbyte = '0;
        pcnt  = 0;
      end
    endfunction

    function void release_bits(bit b);
      put_bit(b);
      while (pend > 0) begin
        put_bit(!b);
        pend--;
      end
    endfunction

    function void close_item(logic [1:0] st);
      if (item_beats.size() == 0) push_beat(8'h00, 1'b0, st);
      item_beats[item_beats.size() - 1].last = 1'b1;
      foreach (item_beats[i]) expected_beats = {expected_beats, item_beats[i]};
    endfunction

    // advance the coder by one accepted input beat and queue its output beats
    function void note_item(in_item_t it);
      logic [31:0] s_lo;
      logic [31:0] s_hi;
      int unsigned s_pend;
      int unsigned s_pcnt;
      logic [7:0]  s_pbyte;
      logic [32:0] span;
      logic [63:0] top;
      logic [63:0] bot;
      bit          done;
      item_beats.delete();
      overflowed = 1'b0;
      if (it.command == CMD_FINISH) begin
        pend++;
        release_bits(lo >= QUARTER);
        if (pcnt != 0) push_beat(pbyte << (8 - pcnt), 1'b1, STAT_OK);
        clear_coder();
        close_item(STAT_OK);
        return;
      end
      if (it.sym_high <= {1'b0, it.sym_low} || it.sym_high > SCALE_TOTAL) begin
        close_item(STAT_BAD);
        return;
      end
      s_lo = lo; s_hi = hi; s_pend = pend; s_pcnt = pcnt; s_pbyte = pbyte;
      span = {1'b0, hi} - {1'b0, lo} + 33'd1;
      top  = (64'(span) * 64'(it.sym_high)) >> 16;
      bot  = (64'(span) * 64'(it.sym_low)) >> 16;
      hi   = lo + top[31:0] - 32'd1;
      lo   = lo + bot[31:0];
      done = 1'b0;
      while (!done) begin
        if (hi < HALF) begin
          release_bits(1'b0);
        end else if (lo >= HALF) begin
          release_bits(1'b1);
          lo -= HALF;
          hi -= HALF;
        end else if (lo >= QUARTER && hi < THREE_QUARTERS) begin
          if (pend >= PENDING_LIMIT) begin
            overflowed = 1'b1;
            done = 1'b1;
          end else begin
            pend++;
            lo -= QUARTER;
            hi -= QUARTER;
          end
        end else begin
          done = 1'b1;
        end
        if (!done) begin
          lo = lo << 1;
          hi = {hi[30:0], 1'b1};
        end
      end
      if (overflowed) begin
        lo = s_lo; hi = s_hi; pend = s_pend; pcnt = s_pcnt; pbyte = s_pbyte;
        item_beats.delete();
        close_item(STAT_OVF);
      end else begin
        close_item(STAT_OK);
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_beat(out_item_t got);
      out_item_t want;
      beats_seen++;
      if (expected_beats.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing expected (%h)", beats_seen, got));
        return;
      end
      want = expected_beats.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("beat %0d out_byte %h, want %h", beats_seen, got.out_byte,
                         want.out_byte));
      if (got.byte_valid !== want.byte_valid)
        report($sformatf("beat %0d byte_valid %b, want %b", beats_seen, got.byte_valid,
                         want.byte_valid));
      if (got.last !== want.last)
        report($sformatf("beat %0d last %b, want %b", beats_seen, got.last, want.last));
      if (got.status !== want.status)
        report($sformatf("beat %0d status %0d, want %0d", beats_seen, got.status,
                         want.status));
    endtask
  endclass

endpackage

[tb/sv/arithmetic_encoder_cdf16_core_tb.sv]
`timescale 1ns / 100ps
// Testbench top for arithmetic_encoder_cdf16_core: stimulus, handshakes, watchdog and verdict.
module arithmetic_encoder_cdf16_core_tb;
  import aec16_pkg::*;
  import aec16_tb_pkg::*;

  localparam int ITEM_COUNT   = 280;
  localparam int IDLE_LIMIT   = 4000;  // cycles without any beat before giving up
  localparam int DRAIN_CYCLES = 320;   // worst item: long renorm plus a full pending release

  // receiver stall patterns
  localparam int READY_ALWAYS = 0;
  localparam int READY_COIN   = 1;
  localparam int READY_STALLS = 2;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_beat;

  coded_byte_board board;
  int unsigned     burst_left;
  int unsigned     idle_cycles;

  arithmetic_encoder_cdf16_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Output monitor and watchdog. Sampling right at the rising edge sees the
  // values the DUT registered on, before its own updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) board.check_beat(out_beat);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  // Receiver: stretches of steady ready, coin-flip ready, and bursty stalls,
  // so back-pressure lands mid-byte, mid-release and at pad.
  initial begin
    int unsigned mode;
    int unsigned stretch;
    int unsigned hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      mode    = $urandom_range(READY_ALWAYS, READY_STALLS);
      stretch = $urandom_range(16, 96);
      while (stretch > 0) begin
        @(negedge clk);
        case (mode)
          READY_ALWAYS: begin
            out_ready = 1'b1;
          end
          READY_COIN: begin
            out_ready = 1'($urandom_range(0, 1));
          end
          default: begin
            if (hold > 0) begin
              out_ready = 1'b0;
              hold--;
            end else if ($urandom_range(0, 9) == 0) begin
              hold = $urandom_range(1, 20);
              out_ready = 1'b0;
            end else begin
              out_ready = 1'b1;
            end
          end
        endcase
        stretch--;
      end
    end
  end

  // Present one input beat and hold it until accepted. The sender runs in
  // bursts; between most bursts valid drops for a random gap.
  // in_ready is only up in idle, so a long gap leaves the DUT waiting.
  task automatic feed(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (!in_ready);
    board.note_item(it);
    burst_left--;
  endtask

  task automatic send_encode(input logic [15:0] slo, input logic [16:0] shi);
    in_item_t it;
    it.command  = CMD_ENCODE;
    it.sym_low  = slo;
    it.sym_high = shi;
    feed(it);
  endtask

  // operand fields ride along but must be ignored by the DUT
  task automatic send_finish(input logic [15:0] slo, input logic [16:0] shi);
    in_item_t it;
    it.command  = CMD_FINISH;
    it.sym_low  = slo;
    it.sym_high = shi;
    feed(it);
  endtask

  // Tight 3/65536 window placed across the coder midpoint: forces a run of
  // E3 steps, which is the only way to pile up pending bits.
  task automatic send_middle();
    logic [15:0] s;
    s = board.middle_symbol();
    send_encode(s - 16'd1, {1'b0, s} + 17'd2);
  endtask

  initial begin
    int unsigned sent;
    int unsigned run;
    int unsigned kind;
    int unsigned slo_v;
    int unsigned shi_v;
    int unsigned w;
    logic [63:0] noise;
    board       = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    burst_left  = 0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed ---
    send_encode(16'h0000, 17'h10000);  // whole scale: no narrowing, status-only beat
    send_encode(16'h0000, 17'h00001);  // narrowest at the bottom, run of zeros
    send_encode(16'hffff, 17'h10000);  // narrowest at the top, run of ones
    send_encode(16'd1234, 17'd1234);   // empty interval
    send_encode(16'hffff, 17'h00000);  // high below low
    send_encode(16'h0000, 17'h10001);  // high just past the scale
    send_encode(16'hffff, 17'h1ffff);  // every operand bit set, out of range
    send_encode(16'h5555, 17'h0aaaa);
    send_finish(16'hffff, 17'h1ffff);
    send_finish(16'h0000, 17'h00000);  // finish on a fresh coder: closing bits and pad
    // pile pending bits up to the limit until an encode is refused
    run = 0;
    do begin
      send_middle();
      run++;
    end while (!board.overflowed && run < 30);
    send_finish(16'h0000, 17'h00000);  // flushes a maximal pending run

    // --- random ---
    sent = 0;
    while (sent < ITEM_COUNT) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        slo_v = $urandom_range(0, 65535);
        case ($urandom_range(0, 2))
          0:       w = $urandom_range(1, 16);
          1:       w = $urandom_range(1, 4096);
          default: w = $urandom_range(1, 65536);
        endcase
        shi_v = slo_v + w;
        if (shi_v > 65536) shi_v = 65536;
        send_encode(slo_v[15:0], shi_v[16:0]);
      end else if (kind < 60) begin
        // middle runs; the long ones reach the pending limit
        run = $urandom_range(3, 22);
        repeat (run) send_middle();
        sent += run - 1;
      end else if (kind < 70) begin
        send_finish(16'($urandom_range(0, 65535)), 17'($urandom_range(0, 131071)));
      end else if (kind < 78) begin
        slo_v = $urandom_range(0, 65535);
        if ($urandom_range(0, 1) == 0) shi_v = $urandom_range(0, slo_v);
        else                           shi_v = $urandom_range(65537, 131071);
        send_encode(slo_v[15:0], shi_v[16:0]);
      end else if (kind < 83) begin
        noise = {$urandom, $urandom};
        feed(noise[33:0]);
      end else begin
        // symbols hugging either end of the scale
        w = $urandom_range(1, 64);
        if ($urandom_range(0, 1) == 0) send_encode(16'h0000, w[16:0]);
        else                           send_encode(16'(65536 - w), 17'h10000);
      end
      sent++;
    end
    send_finish(16'h0000, 17'h00000);

    @(negedge clk);
    in_valid = 1'b0;
    while (board.expected_beats.size() != 0) @(posedge clk);
    // anything showing up now is an extra beat and fails in the monitor
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
src/aec16_pkg.sv
src/arithmetic_encoder_cdf16_core.sv
tb/sv/aec16_tb_pkg.sv
tb/sv/arithmetic_encoder_cdf16_core_tb.sv
